// ===== src/mi3lu_pkg.sv =====
// Shared widths and codes for the 3x3 matrix inverse pipeline.
`default_nettype none
package mi3lu_pkg;
  localparam int DATA_W = 32;   // matrix and inverse entries
  localparam int PROD_W = 64;   // one 32x32 product
  localparam int COF_W  = 65;   // signed cofactor
  localparam int CMAG_W = 64;   // cofactor magnitude
  localparam int DET_W  = 96;   // determinant magnitude
  localparam int DETS_W = 99;   // signed determinant sum
  localparam int QBITS  = 34;   // quotient bits incl. one rounding bit
  localparam int LANES  = 9;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SING = 2'd1,
    ST_SAT  = 2'd2
  } status_e;
endpackage
`default_nettype wire

// ===== src/mi3lu_div.sv =====
// Nine-lane pipelined restoring divider with rounding and saturation.
`default_nettype none
module mi3lu_div
  import mi3lu_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic                          sing_i,
  input  wire logic [LANES-1:0][CMAG_W-1:0]  cof_mag_i,
  input  wire logic [LANES-1:0]              neg_i,
  input  wire logic [DET_W-1:0]              det_mag_i,
  output logic                               valid_o,
  output logic [LANES-1:0][DATA_W-1:0]       res_o,
  output status_e                            status_o
);
  localparam int NUM_W = CMAG_W + 2 * FRAC_BITS + 1;
  localparam int HI_W  = NUM_W - QBITS;
  localparam int NS    = QBITS + 1;

  logic [DET_W-1:0] rem_q [NS][LANES];
  logic [DET_W-1:0] rem_d [NS][LANES];
  logic [QBITS-1:0] low_q [NS][LANES];
  logic [QBITS-1:0] low_d [NS][LANES];
  logic [QBITS-1:0] quo_q [NS][LANES];
  logic [QBITS-1:0] quo_d [NS][LANES];
  logic [LANES-1:0] neg_q [NS];
  logic [LANES-1:0] ovf_q [NS];
  logic [LANES-1:0] ovf_d;
  logic [DET_W-1:0] det_q [NS];
  logic [NS-1:0]    sing_q;
  logic [NS-1:0]    vld_q;

  logic [LANES-1:0][DATA_W-1:0] res_q;
  logic [LANES-1:0][DATA_W-1:0] res_d;
  status_e                      status_q;
  status_e                      status_d;
  logic                         vld_out_q;

  always_comb begin
    logic [NUM_W-1:0]  num;
    logic [DET_W:0]    t;
    logic [DET_W:0]    diff;
    logic              ge;
    for (int l = 0; l < LANES; l++) begin
      num         = {cof_mag_i[l], {(2 * FRAC_BITS + 1){1'b0}}};
      // A quotient of 2^QBITS or more cannot fit any output.
      ovf_d[l]    = DET_W'(num[NUM_W-1:QBITS]) >= det_mag_i;
      rem_d[0][l] = DET_W'(num[NUM_W-1:QBITS]);
      low_d[0][l] = num[QBITS-1:0];
      quo_d[0][l] = '0;
    end
    for (int s = 1; s < NS; s++) begin
      for (int l = 0; l < LANES; l++) begin
        t           = {rem_q[s-1][l], low_q[s-1][l][QBITS-1]};
        diff        = t - {1'b0, det_q[s-1]};
        ge          = t >= {1'b0, det_q[s-1]};
        rem_d[s][l] = ge ? diff[DET_W-1:0] : t[DET_W-1:0];
        low_d[s][l] = {low_q[s-1][l][QBITS-2:0], 1'b0};
        quo_d[s][l] = {quo_q[s-1][l][QBITS-2:0], ge};
      end
    end
  end

  // Final stage: round half away from zero, then saturate to 32 bits; zero if singular.
  always_comb begin
    logic [QBITS:0]   qr;
    logic [QBITS-1:0] q;
    logic             sat;
    logic             any_sat;
    any_sat = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      qr = (QBITS + 1)'(quo_q[NS-1][l]) + (QBITS + 1)'(1);
      q  = qr[QBITS:1];
      if (neg_q[NS-1][l]) begin
        sat = ovf_q[NS-1][l] || (q > QBITS'({1'b1, {(DATA_W - 1){1'b0}}}));
        res_d[l] = sat ? {1'b1, {(DATA_W - 1){1'b0}}} : DATA_W'(-q[DATA_W-1:0]);
      end else begin
        sat = ovf_q[NS-1][l] || (q > QBITS'({1'b0, {(DATA_W - 1){1'b1}}}));
        res_d[l] = sat ? {1'b0, {(DATA_W - 1){1'b1}}} : q[DATA_W-1:0];
      end
      any_sat = any_sat | sat;
    end
    if (sing_q[NS-1]) begin
      res_d    = '0;
      status_d = ST_SING;
    end else if (any_sat) begin
      status_d = ST_SAT;
    end else begin
      status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[NS-2:0], valid_i};
      vld_out_q <= vld_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rem_d[0];
      low_q[0]  <= low_d[0];
      quo_q[0]  <= quo_d[0];
      neg_q[0]  <= neg_i;
      ovf_q[0]  <= ovf_d;
      det_q[0]  <= det_mag_i;
      sing_q[0] <= sing_i;
      for (int s = 1; s < NS; s++) begin
        rem_q[s]  <= rem_d[s];
        low_q[s]  <= low_d[s];
        quo_q[s]  <= quo_d[s];
        neg_q[s]  <= neg_q[s-1];
        ovf_q[s]  <= ovf_q[s-1];
        det_q[s]  <= det_q[s-1];
        sing_q[s] <= sing_q[s-1];
      end
      res_q    <= res_d;
      status_q <= status_d;
    end
  end

  assign valid_o  = vld_out_q;
  assign res_o    = res_q;
  assign status_o = status_q;
endmodule
`default_nettype wire

// ===== src/matrix_inverse_3x3_lu.sv =====
// Top level: pipelined inverse of a 3x3 signed fixed-point matrix.
//
//   channel | handshake          | beat
//   --------+--------------------+-------------------------------
//   in      | valid_i / stall_o  | m00_i .. m22_i
//   out     | valid_o / stall_i  | inv00_o .. inv22_o, status_o
//
// One matrix enters per cycle while stall_o is low and passes 44 register
// stages: eight for the cofactors and the determinant, one divider input
// stage, 34 quotient stages and one rounding stage.
// Reset clears only the valid bits; no clearing pass is needed.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
`default_nettype none
module matrix_inverse_3x3_lu
  import mi3lu_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   stall_o,
  input  wire logic [DATA_W-1:0] m00_i,
  input  wire logic [DATA_W-1:0] m01_i,
  input  wire logic [DATA_W-1:0] m02_i,
  input  wire logic [DATA_W-1:0] m10_i,
  input  wire logic [DATA_W-1:0] m11_i,
  input  wire logic [DATA_W-1:0] m12_i,
  input  wire logic [DATA_W-1:0] m20_i,
  input  wire logic [DATA_W-1:0] m21_i,
  input  wire logic [DATA_W-1:0] m22_i,
  output logic                   valid_o,
  input  wire logic              stall_i,
  output logic [DATA_W-1:0]      inv00_o,
  output logic [DATA_W-1:0]      inv01_o,
  output logic [DATA_W-1:0]      inv02_o,
  output logic [DATA_W-1:0]      inv10_o,
  output logic [DATA_W-1:0]      inv11_o,
  output logic [DATA_W-1:0]      inv12_o,
  output logic [DATA_W-1:0]      inv20_o,
  output logic [DATA_W-1:0]      inv21_o,
  output logic [DATA_W-1:0]      inv22_o,
  output logic [1:0]             status_o
);
  logic en;
  logic [7:0] vld_q;

  logic signed [DATA_W-1:0] a_q [3][3];
  logic signed [PROD_W-1:0] pp_q [3][3];
  logic signed [PROD_W-1:0] pn_q [3][3];
  logic signed [DATA_W-1:0] a0_q1 [3];
  logic signed [COF_W-1:0]  cof_q [3][3];
  logic signed [DATA_W-1:0] a0_q2 [3];
  logic signed [DATA_W-1:0] a0_q3 [3];
  logic [PROD_W-1:0]        plo_q [3];
  logic [PROD_W-1:0]        phi_q [3];
  logic [2:0]               tsg_q;
  logic signed [DET_W:0]    term_q [3];
  logic signed [DETS_W-1:0] det_q;
  logic [DET_W-1:0]         dmag_q;
  logic                     dneg_q;
  logic                     dzero_q;
  // Cofactor magnitudes and signs, carried along the determinant stages.
  logic [CMAG_W-1:0]        cm_q [5][3][3];
  logic                     cs_q [5][3][3];

  logic [LANES-1:0][CMAG_W-1:0] lane_mag;
  logic [LANES-1:0]             lane_neg;
  logic [LANES-1:0][DATA_W-1:0] res;
  status_e                      status;

  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[6:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [COF_W-1:0] c;
    logic [DATA_W-1:0]       am;
    logic signed [DETS_W-1:0] dabs;
    if (en) begin
      a_q[0][0] <= m00_i; a_q[0][1] <= m01_i; a_q[0][2] <= m02_i;
      a_q[1][0] <= m10_i; a_q[1][1] <= m11_i; a_q[1][2] <= m12_i;
      a_q[2][0] <= m20_i; a_q[2][1] <= m21_i; a_q[2][2] <= m22_i;
      // Cofactor products.
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pp_q[i][j] <= PROD_W'(a_q[(i+1)%3][(j+1)%3]) * PROD_W'(a_q[(i+2)%3][(j+2)%3]);
          pn_q[i][j] <= PROD_W'(a_q[(i+1)%3][(j+2)%3]) * PROD_W'(a_q[(i+2)%3][(j+1)%3]);
        end
      end
      a0_q1 <= a_q[0];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          cof_q[i][j] <= COF_W'(pp_q[i][j]) - COF_W'(pn_q[i][j]);
        end
      end
      a0_q2 <= a0_q1;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          c = cof_q[i][j][COF_W-1] ? -cof_q[i][j] : cof_q[i][j];
          cm_q[0][i][j] <= c[CMAG_W-1:0];
          cs_q[0][i][j] <= cof_q[i][j][COF_W-1];
        end
      end
      a0_q3 <= a0_q2;
      // Determinant terms as magnitude times split cofactor magnitude.
      for (int j = 0; j < 3; j++) begin
        am       = a0_q3[j][DATA_W-1] ? DATA_W'(-a0_q3[j]) : DATA_W'(a0_q3[j]);
        plo_q[j] <= PROD_W'(am) * PROD_W'(cm_q[0][0][j][31:0]);
        phi_q[j] <= PROD_W'(am) * PROD_W'(cm_q[0][0][j][63:32]);
        tsg_q[j] <= a0_q3[j][DATA_W-1] ^ cs_q[0][0][j];
      end
      for (int j = 0; j < 3; j++) begin
        term_q[j] <= tsg_q[j]
            ? -$signed({1'b0, DET_W'(plo_q[j]) + {phi_q[j], 32'b0}})
            :  $signed({1'b0, DET_W'(plo_q[j]) + {phi_q[j], 32'b0}});
      end
      det_q <= DETS_W'(term_q[0]) + DETS_W'(term_q[1]) + DETS_W'(term_q[2]);
      dabs    = det_q[DETS_W-1] ? -det_q : det_q;
      dmag_q  <= dabs[DET_W-1:0];
      dneg_q  <= det_q[DETS_W-1];
      dzero_q <= (det_q == '0);
      for (int s = 1; s < 5; s++) begin
        cm_q[s] <= cm_q[s-1];
        cs_q[s] <= cs_q[s-1];
      end
    end
  end

  // Inverse entry (i, j) comes from cofactor (j, i).
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        lane_mag[i*3+j] = cm_q[4][j][i];
        lane_neg[i*3+j] = cs_q[4][j][i] ^ dneg_q;
      end
    end
  end

  mi3lu_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (vld_q[7]),
    .sing_i    (dzero_q),
    .cof_mag_i (lane_mag),
    .neg_i     (lane_neg),
    .det_mag_i (dmag_q),
    .valid_o   (valid_o),
    .res_o     (res),
    .status_o  (status)
  );

  assign inv00_o  = res[0];
  assign inv01_o  = res[1];
  assign inv02_o  = res[2];
  assign inv10_o  = res[3];
  assign inv11_o  = res[4];
  assign inv12_o  = res[5];
  assign inv20_o  = res[6];
  assign inv21_o  = res[7];
  assign inv22_o  = res[8];
  assign status_o = status;
endmodule
`default_nettype wire

// ===== dv/matrix_inverse_3x3_lu_test.sv =====
// Testbench for the 3x3 fixed-point matrix inverse: directed and random matrices.
`timescale 1ns / 1ps
module matrix_inverse_3x3_lu_test
  import mi3lu_pkg::*;
();

  localparam int FRAC      = 16;
  localparam int LATENCY   = 44;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [31:0] ONE = 32'h0001_0000;

  typedef logic [8:0][31:0] matrix_t;
  typedef struct packed {
    logic [8:0][31:0] inv;
    status_e          st;
  } inverse_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_i = 1'b0;
  logic        stall_o, valid_o;
  matrix_t     mat_q = '0;
  logic [31:0] inv_o [9];
  logic [1:0]  status_o;

  inverse_t expected_inv_q[$];
  int       error_count = 0;
  int       idle_cycles = 0;
  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  matrix_inverse_3x3_lu #(.FRAC_BITS(FRAC)) u_dut (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .m00_i(mat_q[0]), .m01_i(mat_q[1]), .m02_i(mat_q[2]),
    .m10_i(mat_q[3]), .m11_i(mat_q[4]), .m12_i(mat_q[5]),
    .m20_i(mat_q[6]), .m21_i(mat_q[7]), .m22_i(mat_q[8]),
    .valid_o, .stall_i,
    .inv00_o(inv_o[0]), .inv01_o(inv_o[1]), .inv02_o(inv_o[2]),
    .inv10_o(inv_o[3]), .inv11_o(inv_o[4]), .inv12_o(inv_o[5]),
    .inv20_o(inv_o[6]), .inv21_o(inv_o[7]), .inv22_o(inv_o[8]),
    .status_o
  );

  // Exact inverse: adjugate over determinant, rounded once, ties away from zero.
  function automatic inverse_t predict_inverse(input matrix_t m);
    logic signed [127:0] a [9];
    logic signed [127:0] cof [9];
    logic signed [127:0] det, c;
    logic [127:0] dmag, num, q, r;
    logic neg;
    inverse_t res;
    int r1, r2, c1, c2;
    for (int k = 0; k < 9; k++) a[k] = {{96{m[k][31]}}, m[k]};
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r1 = (i + 1) % 3; r2 = (i + 2) % 3;
        c1 = (j + 1) % 3; c2 = (j + 2) % 3;
        cof[i*3+j] = a[r1*3+c1] * a[r2*3+c2] - a[r1*3+c2] * a[r2*3+c1];
      end
    end
    det = a[0] * cof[0] + a[1] * cof[1] + a[2] * cof[2];
    res.inv = '0;
    if (det == 0) begin
      res.st = ST_SING;
      return res;
    end
    res.st = ST_OK;
    dmag = det < 0 ? -det : det;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        c = cof[j*3+i];
        neg = (c < 0) != (det < 0);
        num = (c < 0 ? -c : c);
        num = num << (2 * FRAC);
        q = num / dmag;
        r = num - q * dmag;
        if ((r << 1) >= dmag) q = q + 1;
        if (q == 0) begin
          res.inv[i*3+j] = '0;
        end else if (!neg) begin
          if (q > 128'h7FFF_FFFF) begin
            res.inv[i*3+j] = 32'h7FFF_FFFF;
            res.st = ST_SAT;
          end else res.inv[i*3+j] = q[31:0];
        end else begin
          if (q > 128'h8000_0000) begin
            res.inv[i*3+j] = 32'h8000_0000;
            res.st = ST_SAT;
          end else res.inv[i*3+j] = -q[31:0];
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $time, field, got, want);
    error_count++;
  endtask

  // Receiver: random stall and result check.
  always @(posedge clk_i) begin
    inverse_t want;
    stall_i <= ($urandom_range(99) < rx_idle_pct);
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_inv_q.size() == 0) begin
        report_mismatch("beat with no matrix outstanding", 32'(status_o), '0);
      end else begin
        want = expected_inv_q.pop_front();
        for (int k = 0; k < 9; k++)
          if (inv_o[k] !== want.inv[k])
            report_mismatch($sformatf("inv%0d%0d", k / 3, k % 3), inv_o[k], want.inv[k]);
        if (status_o !== want.st) report_mismatch("status", 32'(status_o), 32'(want.st));
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // The beat stays valid until a later idle cycle or a drain lowers it.
  task automatic send_matrix(input matrix_t m);
    while ($urandom_range(99) < tx_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    mat_q <= m;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    expected_inv_q = {expected_inv_q, predict_inverse(m)};
  endtask

  task automatic wait_drained();
    valid_i <= 1'b0;
    while (expected_inv_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] small_entry();
    return 32'($signed($urandom_range(0, 8 << FRAC)) - $signed(4 << FRAC));
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t m;
    int k;
    int kind = $urandom_range(9);
    for (int i = 0; i < 9; i++) m[i] = small_entry();
    case (kind)
      0, 1: begin
        for (int i = 0; i < 9; i++) m[i] = $urandom;
      end
      2: begin
        // Tiny entries drive the inverse into saturation.
        for (int i = 0; i < 9; i++) m[i] = 32'($signed($urandom_range(0, 64)) - 32);
      end
      3: begin
        // Dependent rows leave the matrix singular.
        k = $urandom_range(2);
        for (int j = 0; j < 3; j++) m[k*3+j] = m[((k + 1) % 3)*3+j];
      end
      4: m[0] = '0;
      5: begin
        m[0] = '0;
        m[3] = '0;
      end
      6: begin
        // Row 1 leads with a multiple of row 0, so the second pivot is zero.
        k = $signed($urandom_range(0, 6)) - 3;
        m[3] = 32'($signed(m[0]) * k);
        m[4] = 32'($signed(m[1]) * k);
      end
      7: begin
        for (int i = 0; i < 9; i++)
          m[i] = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      default: ;
    endcase
    return m;
  endfunction

  task automatic test_directed();
    matrix_t m;
    m = '0;
    send_matrix(m);
    m[0] = ONE; m[4] = ONE; m[8] = ONE;
    send_matrix(m);
    m = {9{32'h7FFF_FFFF}};
    send_matrix(m);
    m = {9{32'h8000_0000}};
    send_matrix(m);
    m = '0;
    m[0] = 32'h8000_0000; m[4] = 32'h7FFF_FFFF; m[8] = 32'h8000_0000;
    send_matrix(m);
    m = '0;
    m[0] = 32'd1; m[4] = 32'd1; m[8] = 32'hFFFF_FFFF;
    send_matrix(m);
    m = '0;
    m[0] = 32'd2 << FRAC; m[4] = 32'd3 << FRAC; m[8] = 32'd7 << FRAC;
    send_matrix(m);
    // First pivot zero: two permutation matrices with a zero top-left entry.
    m = '0;
    m[1] = ONE; m[3] = ONE; m[8] = ONE;
    send_matrix(m);
    m = '0;
    m[1] = ONE; m[5] = ONE; m[6] = ONE;
    send_matrix(m);
    // Second pivot zero: rows 0 and 1 share their first two entries.
    m = '0;
    m[0] = ONE; m[1] = ONE; m[3] = ONE; m[4] = ONE; m[5] = ONE; m[7] = ONE;
    m[8] = 32'd5 << FRAC;
    send_matrix(m);
    // Zero pivot that survives: first column all zero.
    m = {9{ONE}};
    m[0] = '0; m[3] = '0; m[6] = '0;
    send_matrix(m);
    for (int k = 0; k < 9; k++) m[k] = $urandom;
    m[6] = m[0]; m[7] = m[1]; m[8] = m[2];
    send_matrix(m);
    m = '0;
    m[0] = 32'hFFFF_FFFF; m[1] = 32'h0000_FFFF; m[2] = 32'hFFFF_0000;
    m[3] = 32'h5555_5555; m[4] = 32'hAAAA_AAAA; m[5] = 32'h1234_5678;
    m[6] = 32'h8765_4321; m[7] = 32'h0F0F_0F0F; m[8] = 32'hF0F0_F0F0;
    send_matrix(m);
  endtask

  task automatic test_random(input int count, input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int n = 0; n < count; n++) send_matrix(random_matrix());
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(410, 32, 78);
    // Let the pipeline run dry before the next phase.
    wait_drained();
    test_random(410, 78, 32);
    test_random(420, 0, 0);
    wait_drained();
    repeat (LATENCY + 16) @(posedge clk_i);
    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
